/* rtl/topk_pkg.sv */
package topk_pkg;

  localparam int KEEP_W = 5;
  localparam int MAX_KEEP_DEF = 16;
  localparam longint unsigned MAX_LENGTH_DEF = 64'd65536;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_LONG = 2'd2
  } status_t;

  typedef enum logic {
    S_ACCEPT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] element_value;
    logic        final_element;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        result_last;
    status_t     result_status;
  } out_item_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  function automatic logic is_nan(input logic [31:0] bits);
    return bits[30:0] > 31'h7F80_0000;
  endfunction

  // monotonic unsigned key for non-nan floats, both zeros map to one key
  function automatic logic [31:0] sort_key(input logic [31:0] bits);
    logic [31:0] k;
    if (bits[30:0] == 31'd0) begin
      k = 32'h8000_0000;
    end else if (bits[31]) begin
      k = ~bits;
    end else begin
      k = {1'b1, bits[30:0]};
    end
    return k;
  endfunction

endpackage

/* rtl/topk_cell.sv */
module topk_cell (
  input  logic                clk,
  input  topk_pkg::cell_ctl_t ctl,
  input  logic                valid,
  input  logic [31:0]         new_value,
  input  logic [31:0]         new_key,
  input  logic                prev_gt,
  input  logic [31:0]         prev_value,
  input  logic [31:0]         next_value,
  output logic [31:0]         value,
  output logic                gt,
  output logic                beat
);

  logic [31:0] value_r;
  logic [31:0] value_nxt;
  logic [31:0] key;

  assign key   = topk_pkg::sort_key(value_r);
  assign gt    = valid && (key > new_key);
  assign beat  = new_key > key;
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      // entries above the insertion point hold, the rest move one place down
      if (!gt) begin
        value_nxt = prev_gt ? new_value : prev_value;
      end
    end else if (ctl.shift) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

/* rtl/streaming_top_k_select_unit.sv */
// channel | ports                          | transaction
// input   | in_valid, in_stall, in_data    | one float32 element, final flag
// result  | out_valid, out_stall, out_data | one kept value or one error
// config  | cfg_wr_en, cfg_wr_data         | keep count k
//
// one element per cycle while a vector streams in; the sorted insertion
// chain of MAX_KEEP cells takes in each accepted element as it arrives.
// after the final element the chain shifts out through the output register,
// one value per cycle unless out_stall holds it (k values, or one for an error), in_stall held high.
// out_stall freezes that shift; the output register keeps its transaction.
// rst_n is synchronous; kept values are not cleared, only control state such as the fill count.
module streaming_top_k_select_unit #(
  parameter int              MAX_KEEP   = topk_pkg::MAX_KEEP_DEF,
  parameter longint unsigned MAX_LENGTH = topk_pkg::MAX_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  topk_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output topk_pkg::out_item_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [topk_pkg::KEEP_W-1:0] cfg_wr_data
);

  localparam int KW    = $clog2(MAX_KEEP + 1);
  localparam int IW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam logic [POS_W-1:0] LEN_LIM = POS_W'(MAX_LENGTH);

  topk_pkg::state_t state_r, state_nxt;
  logic [topk_pkg::KEEP_W-1:0] keep_count_r;
  logic [KW-1:0]    fill_r, fill_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic             err_r, err_nxt;
  topk_pkg::status_t err_code_r, err_code_nxt;
  logic [KW-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  topk_pkg::out_item_t out_data_r, out_data_nxt;

  logic [KW-1:0]    eff_k;
  logic             in_acc;
  logic             load;
  logic             emit_last;
  logic             ins_ok;
  logic [31:0]      new_key;
  logic [KW-1:0]    fill_m1;
  topk_pkg::cell_ctl_t ctl;

  logic [31:0]         cell_val  [MAX_KEEP];
  logic [MAX_KEEP-1:0] cell_gt;
  logic [MAX_KEEP-1:0] cell_beat;

  always_comb begin
    if (keep_count_r == '0) begin
      eff_k = KW'(1);
    end else if (32'(keep_count_r) > MAX_KEEP) begin
      eff_k = KW'(MAX_KEEP);
    end else begin
      eff_k = KW'(keep_count_r);
    end
  end

  assign in_acc    = in_valid && !in_stall;
  assign new_key   = topk_pkg::sort_key(in_data.element_value);
  assign fill_m1   = fill_r - KW'(1);
  assign load      = (state_r == topk_pkg::S_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = err_r || (emit_cnt_r == KW'(1));

  // insertion allowed for a non-nan element within the length limit when there is room, or when it beats the smallest
  always_comb begin
    ins_ok = 1'b0;
    if (in_acc && (pos_r != LEN_LIM) && !topk_pkg::is_nan(in_data.element_value)) begin
      if (fill_r < eff_k) begin
        ins_ok = 1'b1;
      end else if (fill_r != '0) begin
        ins_ok = cell_beat[fill_m1[IW-1:0]];
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
      logic        prev_gt;
      logic [31:0] prev_value;
      logic [31:0] next_value;
      if (gi == 0) begin : g_head
        assign prev_gt    = 1'b1;
        assign prev_value = '0;
      end else begin : g_body
        assign prev_gt    = cell_gt[gi-1];
        assign prev_value = cell_val[gi-1];
      end
      if (gi == MAX_KEEP - 1) begin : g_tail
        assign next_value = '0;
      end else begin : g_mid
        assign next_value = cell_val[gi+1];
      end
      topk_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid      (KW'(gi) < fill_r),
        .new_value  (in_data.element_value),
        .new_key    (new_key),
        .prev_gt    (prev_gt),
        .prev_value (prev_value),
        .next_value (next_value),
        .value      (cell_val[gi]),
        .gt         (cell_gt[gi]),
        .beat       (cell_beat[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      topk_pkg::S_ACCEPT: begin
        if (in_acc && in_data.final_element) begin
          state_nxt = topk_pkg::S_EMIT;
        end
      end
      topk_pkg::S_EMIT: begin
        if (load && emit_last) begin
          state_nxt = topk_pkg::S_ACCEPT;
        end
      end
      default: state_nxt = topk_pkg::S_ACCEPT;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    ctl.ins   = 1'b0;
    ctl.shift = 1'b0;
    case (state_r)
      topk_pkg::S_ACCEPT: begin
        in_stall = 1'b0;
        ctl.ins  = ins_ok;
      end
      topk_pkg::S_EMIT: begin
        ctl.shift = load;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    ovf_nxt      = ovf_r;
    err_nxt      = err_r;
    err_code_nxt = err_code_r;
    emit_cnt_nxt = emit_cnt_r;
    if (in_acc) begin
      if (pos_r == LEN_LIM) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (ins_ok && (fill_r < eff_k)) begin
        fill_nxt = fill_r + KW'(1);
      end
      if (in_data.final_element) begin
        err_nxt      = ovf_nxt || (fill_nxt < eff_k);
        err_code_nxt = ovf_nxt ? topk_pkg::STATUS_LONG : topk_pkg::STATUS_FEW;
        emit_cnt_nxt = eff_k;
        // new run starts; chain contents stay for the shift-out
        fill_nxt = '0;
        pos_nxt  = '0;
        ovf_nxt  = 1'b0;
      end
    end else if (load) begin
      emit_cnt_nxt = emit_cnt_r - KW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (err_r) begin
        out_data_nxt.result_value  = '0;
        out_data_nxt.result_last   = 1'b1;
        out_data_nxt.result_status = err_code_r;
      end else begin
        out_data_nxt.result_value  = cell_val[0];
        out_data_nxt.result_last   = emit_last;
        out_data_nxt.result_status = topk_pkg::STATUS_OK;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= topk_pkg::S_ACCEPT;
      keep_count_r <= topk_pkg::KEEP_W'(1);
      fill_r       <= '0;
      pos_r        <= '0;
      ovf_r        <= 1'b0;
      err_r        <= 1'b0;
      emit_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      err_r       <= err_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        keep_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    err_code_r <= err_code_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == topk_pkg::S_EMIT))
    else $error("result appeared without an emit cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_KEEP)
    else $error("fill count beyond chain length");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.result_status != topk_pkg::STATUS_OK)
      |-> out_data_r.result_last)
    else $error("error result not marked last");

  a_no_input_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.final_element |=> state_r == topk_pkg::S_EMIT && in_stall)
    else $error("final element did not start the shift-out");

endmodule
